FILE: sv/acmc_pkg.sv
// Shared constants, item codes, address helper and saturating add for the
// Aho-Corasick match counter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package acmc_pkg;
  localparam int MAX_NODES    = 1024;
  localparam int NODE_W       = 10;
  localparam int NTOT_W       = 11;
  localparam int ALPHABET     = 26;
  localparam int LETTER_W     = 5;
  localparam int CHILD_DEPTH  = MAX_NODES * ALPHABET;
  localparam int CADDR_W      = 15;
  localparam int MAX_PATTERNS = 64;
  localparam int PAT_W        = 6;
  localparam int PTOT_W       = 7;
  localparam int COUNT_W      = 24;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_PAT_LETTER = 2'd0;
  localparam kind_t KIND_PAT_END    = 2'd1;
  localparam kind_t KIND_TEXT       = 2'd2;
  localparam kind_t KIND_FINISH     = 2'd3;

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [CADDR_W-1:0] caddr_t;
  typedef logic [COUNT_W-1:0] count_t;

  function automatic caddr_t child_addr(input node_t node, input logic [LETTER_W-1:0] ltr);
    child_addr = CADDR_W'(CADDR_W'(node) * CADDR_W'(ALPHABET)) + CADDR_W'(ltr);
  endfunction

  function automatic count_t sat_add(input count_t a, input count_t b);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[COUNT_W] ? '1 : s[COUNT_W-1:0];
  endfunction
endpackage
`default_nettype wire

FILE: sv/acmc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered
// read data (old data on a same-address collision).
`timescale 1ns / 1ps
`default_nettype none
module acmc_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 10,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: sv/aho_corasick_match_counter.sv
// Aho-Corasick match counter: trie, failure links and hit counters held in
// synchronous RAMs, walked by one sequencer. Depends on acmc_pkg, acmc_ram.
// Steps: a pattern letter reads, then writes its child entry; an end of pattern
// is taken in the accepting cycle; a text letter reads child and fail link,
// again per fail hop, then reads and writes its hit count. The first text letter
// (or finish) first builds the links; finish pushes counts up, reports, then
// clears node_total*26 child entries. Results cannot be stalled.
// After reset the block sweeps all 26624 child entries (busy high) before
// accepting an item.
`timescale 1ns / 1ps
`default_nettype none
module aho_corasick_match_counter (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [1:0]                     in_kind,
  input  wire logic [acmc_pkg::LETTER_W-1:0]  in_letter,
  output logic                                out_valid,
  output logic [acmc_pkg::PAT_W-1:0]          out_pattern_index,
  output logic [acmc_pkg::COUNT_W-1:0]        out_match_count,
  output logic                                out_overflow,
  output logic                                out_last
);
  import acmc_pkg::*;

  localparam logic [4:0] ST_IDLE  = 5'd0,  ST_CLEAR = 5'd1,  ST_PWR   = 5'd2,
                         ST_BINIT = 5'd3,  ST_BHEAD = 5'd4,  ST_BND   = 5'd5,
                         ST_BCISS = 5'd6,  ST_BCCHK = 5'd7,  ST_BKISS = 5'd8,
                         ST_BKCHK = 5'd9,  ST_SISS  = 5'd10, ST_SCHK  = 5'd11,
                         ST_SHRD  = 5'd12, ST_SHWR  = 5'd13, ST_FIDX  = 5'd14,
                         ST_FND   = 5'd15, ST_FHV   = 5'd16, ST_FADD  = 5'd17,
                         ST_RISS  = 5'd18, ST_RHRD  = 5'd19, ST_ROUT  = 5'd20;

  logic [4:0]          state_r, state_nxt;
  logic [NTOT_W-1:0]   ntot_r, ntot_nxt;
  logic [PTOT_W-1:0]   ptot_r, ptot_nxt;
  node_t               cursor_r, cursor_nxt;
  node_t               scan_r, scan_nxt;
  logic                phase_r, phase_nxt;
  logic                ovf_r, ovf_nxt;
  kind_t               kind_r, kind_nxt;
  logic [LETTER_W-1:0] let_r, let_nxt;
  logic [LETTER_W-1:0] txt_let_r, txt_let_nxt;
  node_t               k_r, k_nxt;
  node_t               nd_r, nd_nxt;
  node_t               ch_r, ch_nxt;
  count_t              hv_r, hv_nxt;
  logic [NTOT_W-1:0]   head_r, head_nxt;
  logic [NTOT_W-1:0]   tail_r, tail_nxt;
  logic [NTOT_W-1:0]   idx_r, idx_nxt;
  logic [PTOT_W-1:0]   pidx_r, pidx_nxt;
  caddr_t              cnt_r, cnt_nxt;
  caddr_t              lim_r, lim_nxt;
  logic                ov_r, ov_nxt;
  logic [PAT_W-1:0]    opi_r, opi_nxt;
  count_t              ocnt_r, ocnt_nxt;
  logic                oovf_r, oovf_nxt;
  logic                olast_r, olast_nxt;

  // memory ports
  logic   c_we, h_we, f_we, b_we, p_we;
  caddr_t c_wa, c_ra;
  node_t  c_wd, c_rd;
  node_t  h_wa, h_ra, f_wa, f_wd, f_ra, f_rd, b_wa, b_wd, b_ra, b_rd, p_wd, p_rd;
  count_t h_wd, h_rd;
  logic [PAT_W-1:0] p_wa, p_ra;

  acmc_ram #(.DEPTH(CHILD_DEPTH), .WIDTH(NODE_W), .AW(CADDR_W)) u_child (
    .clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd));
  acmc_ram #(.DEPTH(MAX_NODES), .WIDTH(COUNT_W), .AW(NODE_W)) u_hit (
    .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));
  acmc_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W), .AW(NODE_W)) u_fail (
    .clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));
  acmc_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W), .AW(NODE_W)) u_bfs (
    .clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd));
  acmc_ram #(.DEPTH(MAX_PATTERNS), .WIDTH(NODE_W), .AW(PAT_W)) u_pend (
    .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));

  logic accept, let_ok;
  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign let_ok = (in_letter < LETTER_W'(ALPHABET));

  always_comb begin
    state_nxt = state_r;   ntot_nxt = ntot_r;   ptot_nxt = ptot_r;
    cursor_nxt = cursor_r; scan_nxt = scan_r;   phase_nxt = phase_r;
    ovf_nxt = ovf_r;       kind_nxt = kind_r;   let_nxt = let_r;
    txt_let_nxt = txt_let_r;
    k_nxt = k_r;           nd_nxt = nd_r;       ch_nxt = ch_r;
    hv_nxt = hv_r;         head_nxt = head_r;   tail_nxt = tail_r;
    idx_nxt = idx_r;       pidx_nxt = pidx_r;   cnt_nxt = cnt_r;
    lim_nxt = lim_r;       ov_nxt = 1'b0;       opi_nxt = opi_r;
    ocnt_nxt = ocnt_r;     oovf_nxt = oovf_r;   olast_nxt = olast_r;
    c_we = 1'b0; c_wa = '0; c_wd = '0; c_ra = '0;
    h_we = 1'b0; h_wa = '0; h_wd = '0; h_ra = '0;
    f_we = 1'b0; f_wa = '0; f_wd = '0; f_ra = '0;
    b_we = 1'b0; b_wa = '0; b_wd = '0; b_ra = '0;
    p_we = 1'b0; p_wa = '0; p_wd = '0; p_ra = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          kind_nxt = kind_t'(in_kind);
          let_nxt  = in_letter;
          txt_let_nxt = in_letter;
          unique case (kind_t'(in_kind))
            KIND_PAT_LETTER: begin
              if (!phase_r && let_ok) begin
                c_ra = child_addr(cursor_r, in_letter);
                state_nxt = ST_PWR;
              end
            end
            KIND_PAT_END: begin
              if (!phase_r) begin
                if (ptot_r >= PTOT_W'(MAX_PATTERNS)) begin
                  ovf_nxt = 1'b1;
                end else begin
                  p_we = 1'b1;
                  p_wa = ptot_r[PAT_W-1:0];
                  p_wd = cursor_r;
                  ptot_nxt = ptot_r + 1'b1;
                end
                cursor_nxt = '0;
              end
            end
            KIND_TEXT: begin
              if (let_ok) begin
                k_nxt = scan_r;
                state_nxt = phase_r ? ST_SISS : ST_BINIT;
              end
            end
            KIND_FINISH: begin
              idx_nxt = ntot_r;
              state_nxt = phase_r ? ST_FIDX : ST_BINIT;
            end
          endcase
        end
      end
      ST_PWR: begin
        if (c_rd != '0) begin
          cursor_nxt = c_rd;
        end else if (ntot_r >= NTOT_W'(MAX_NODES)) begin
          ovf_nxt = 1'b1;
        end else begin
          c_we = 1'b1;
          c_wa = child_addr(cursor_r, let_r);
          c_wd = ntot_r[NODE_W-1:0];
          cursor_nxt = ntot_r[NODE_W-1:0];
          ntot_nxt = ntot_r + 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      // breadth-first construction of failure links
      ST_BINIT: begin
        b_we = 1'b1; b_wa = '0; b_wd = '0;
        f_we = 1'b1; f_wa = '0; f_wd = '0;
        head_nxt = '0;
        tail_nxt = NTOT_W'(1);
        state_nxt = ST_BHEAD;
      end
      ST_BHEAD: begin
        if (head_r < tail_r && head_r < NTOT_W'(MAX_NODES)) begin
          b_ra = head_r[NODE_W-1:0];
          head_nxt = head_r + 1'b1;
          state_nxt = ST_BND;
        end else begin
          phase_nxt = 1'b1;
          idx_nxt = ntot_r;
          // the build reused k and the letter; restore the pending text item
          k_nxt = scan_r;
          let_nxt = txt_let_r;
          state_nxt = (kind_r == KIND_TEXT) ? ST_SISS : ST_FIDX;
        end
      end
      ST_BND: begin
        nd_nxt = b_rd;
        let_nxt = '0;
        state_nxt = ST_BCISS;
      end
      ST_BCISS: begin
        c_ra = child_addr(nd_r, let_r);
        f_ra = nd_r;
        state_nxt = ST_BCCHK;
      end
      ST_BCCHK: begin
        if (c_rd == '0) begin
          let_nxt = let_r + 1'b1;
          state_nxt = (let_r == LETTER_W'(ALPHABET - 1)) ? ST_BHEAD : ST_BCISS;
        end else begin
          ch_nxt = c_rd;
          k_nxt = f_rd;
          state_nxt = ST_BKISS;
        end
      end
      ST_BKISS: begin
        c_ra = child_addr(k_r, let_r);
        f_ra = k_r;
        state_nxt = ST_BKCHK;
      end
      ST_BKCHK: begin
        if (k_r != '0 && c_rd == '0) begin
          k_nxt = f_rd;
          state_nxt = ST_BKISS;
        end else begin
          f_we = 1'b1;
          f_wa = ch_r;
          f_wd = (c_rd != '0 && c_rd != ch_r) ? c_rd : k_r;
          if (tail_r < NTOT_W'(MAX_NODES)) begin
            b_we = 1'b1;
            b_wa = tail_r[NODE_W-1:0];
            b_wd = ch_r;
            tail_nxt = tail_r + 1'b1;
          end
          let_nxt = let_r + 1'b1;
          state_nxt = (let_r == LETTER_W'(ALPHABET - 1)) ? ST_BHEAD : ST_BCISS;
        end
      end
      // text letter walk
      ST_SISS: begin
        c_ra = child_addr(k_r, let_r);
        f_ra = k_r;
        state_nxt = ST_SCHK;
      end
      ST_SCHK: begin
        if (c_rd != '0) begin
          k_nxt = c_rd;
          state_nxt = ST_SHRD;
        end else if (k_r == '0) begin
          state_nxt = ST_SHRD;
        end else begin
          k_nxt = f_rd;
          state_nxt = ST_SISS;
        end
      end
      ST_SHRD: begin
        h_ra = k_r;
        state_nxt = ST_SHWR;
      end
      ST_SHWR: begin
        h_we = 1'b1;
        h_wa = k_r;
        h_wd = sat_add(h_rd, COUNT_W'(1));
        scan_nxt = k_r;
        state_nxt = ST_IDLE;
      end
      // push counts up the fail links, deepest nodes first
      ST_FIDX: begin
        if (idx_r > NTOT_W'(1)) begin
          b_ra = NODE_W'(idx_r - 1'b1);
          state_nxt = ST_FND;
        end else begin
          pidx_nxt = '0;
          state_nxt = (ptot_r == '0) ? ST_CLEAR : ST_RISS;
          lim_nxt = CADDR_W'(CADDR_W'(ntot_r) * CADDR_W'(ALPHABET));
          cnt_nxt = '0;
        end
      end
      ST_FND: begin
        nd_nxt = b_rd;
        h_ra = b_rd;
        f_ra = b_rd;
        state_nxt = ST_FHV;
      end
      ST_FHV: begin
        if (nd_r != '0 && h_rd != '0) begin
          hv_nxt = h_rd;
          k_nxt = f_rd;
          h_ra = f_rd;
          state_nxt = ST_FADD;
        end else begin
          idx_nxt = idx_r - 1'b1;
          state_nxt = ST_FIDX;
        end
      end
      ST_FADD: begin
        h_we = 1'b1;
        h_wa = k_r;
        h_wd = sat_add(h_rd, hv_r);
        idx_nxt = idx_r - 1'b1;
        state_nxt = ST_FIDX;
      end
      // report one count per pattern
      ST_RISS: begin
        p_ra = pidx_r[PAT_W-1:0];
        state_nxt = ST_RHRD;
      end
      ST_RHRD: begin
        h_ra = p_rd;
        state_nxt = ST_ROUT;
      end
      ST_ROUT: begin
        ov_nxt = 1'b1;
        opi_nxt = pidx_r[PAT_W-1:0];
        ocnt_nxt = h_rd;
        oovf_nxt = ovf_r;
        olast_nxt = (pidx_r + 1'b1 == ptot_r);
        pidx_nxt = pidx_r + 1'b1;
        state_nxt = (pidx_r + 1'b1 == ptot_r) ? ST_CLEAR : ST_RISS;
      end
      ST_CLEAR: begin
        c_we = 1'b1;
        c_wa = cnt_r;
        h_we = (cnt_r < CADDR_W'(MAX_NODES));
        h_wa = cnt_r[NODE_W-1:0];
        ntot_nxt = NTOT_W'(1);
        ptot_nxt = '0;
        cursor_nxt = '0;
        scan_nxt = '0;
        phase_nxt = 1'b0;
        ovf_nxt = 1'b0;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r + 1'b1 == lim_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      ntot_r   <= NTOT_W'(1);
      ptot_r   <= '0;
      cursor_r <= '0;
      scan_r   <= '0;
      phase_r  <= 1'b0;
      ovf_r    <= 1'b0;
      cnt_r    <= '0;
      lim_r    <= CADDR_W'(CHILD_DEPTH);
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ntot_r   <= ntot_nxt;
      ptot_r   <= ptot_nxt;
      cursor_r <= cursor_nxt;
      scan_r   <= scan_nxt;
      phase_r  <= phase_nxt;
      ovf_r    <= ovf_nxt;
      cnt_r    <= cnt_nxt;
      lim_r    <= lim_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    let_r     <= let_nxt;
    txt_let_r <= txt_let_nxt;
    k_r       <= k_nxt;
    nd_r      <= nd_nxt;
    ch_r      <= ch_nxt;
    hv_r      <= hv_nxt;
    head_r    <= head_nxt;
    tail_r    <= tail_nxt;
    idx_r     <= idx_nxt;
    pidx_r    <= pidx_nxt;
    opi_r     <= opi_nxt;
    ocnt_r    <= ocnt_nxt;
    oovf_r    <= oovf_nxt;
    olast_r   <= olast_nxt;
  end

  assign out_valid         = ov_r;
  assign out_pattern_index = opi_r;
  assign out_match_count   = ocnt_r;
  assign out_overflow      = oovf_r;
  assign out_last          = ov_r && olast_r;

`ifndef NO_ASSERTIONS
  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result strobe outside a report");
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> busy) else $error("no clearing sweep after reset");
  a_last_strobed: assert property (@(posedge clk)
    out_last |-> out_valid) else $error("last marker without result");
  a_last_ends_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> !$past(out_valid) || !$past(out_last))
    else $error("two last markers in a row");
`endif
endmodule
`default_nettype wire

FILE: tb/sv/aho_corasick_match_counter_test.sv
// Self-checking testbench for aho_corasick_match_counter: directed and random
// dictionaries and texts, predicted per item. Depends on acmc_pkg and the block.
`timescale 1ns / 1ps
module aho_corasick_match_counter_test;
  import acmc_pkg::*;

  localparam int STALL_LIMIT = 250000;

  typedef struct packed {
    logic [PAT_W-1:0] pidx;
    count_t           cnt;
    logic             ovf;
    logic             lst;
  } tally_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  kind_t               in_kind = KIND_PAT_LETTER;
  logic [LETTER_W-1:0] in_letter = '0;
  logic                out_valid;
  logic [PAT_W-1:0]    out_pattern_index;
  count_t              out_match_count;
  logic                out_overflow;
  logic                out_last;

  aho_corasick_match_counter uut (
    .clk, .rst_n, .start, .busy, .in_kind, .in_letter,
    .out_valid, .out_pattern_index, .out_match_count, .out_overflow, .out_last
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predicted dictionary state
  node_t  kids [CHILD_DEPTH];
  node_t  fails [MAX_NODES];
  count_t hits [MAX_NODES];
  node_t  ends [MAX_PATTERNS];
  node_t  order [MAX_NODES];
  int     node_cnt, pat_cnt, cursor, walker, scanning;
  logic   ovf_seen;

  tally_t expected_tallies [$];
  bit     broken = 1'b0;
  int     idle_pct = 0;
  int     items_sent = 0;
  int     quiet = 0;

  function automatic void clear_dictionary();
    foreach (kids[i]) kids[i] = '0;
    foreach (fails[i]) begin
      fails[i] = '0;
      hits[i] = '0;
      order[i] = '0;
    end
    foreach (ends[i]) ends[i] = '0;
    node_cnt = 1;
    pat_cnt = 0;
    cursor = 0;
    walker = 0;
    scanning = 0;
    ovf_seen = 1'b0;
  endfunction

  function automatic count_t bump(count_t a, count_t b);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
  endfunction

  function automatic void link_trie();
    int head, tail, nd, ch, k;
    head = 0;
    tail = 1;
    order[0] = '0;
    fails[0] = '0;
    while (head < tail && head < MAX_NODES) begin
      nd = order[head];
      head++;
      for (int c = 0; c < ALPHABET; c++) begin
        ch = kids[nd*ALPHABET + c];
        if (ch != 0) begin
          k = fails[nd];
          while (k != 0 && kids[k*ALPHABET + c] == 0) k = fails[k];
          if (kids[k*ALPHABET + c] != 0 && kids[k*ALPHABET + c] != ch)
            k = kids[k*ALPHABET + c];
          fails[ch] = node_t'(k);
          if (tail < MAX_NODES) begin
            order[tail] = node_t'(ch);
            tail++;
          end
        end
      end
    end
    scanning = 1;
  endfunction

  // advances the predicted dictionary by one accepted item
  function automatic void predict_tallies(kind_t kind, logic [LETTER_W-1:0] ltr);
    int ch, k, nd;
    tally_t t;
    case (kind)
      KIND_PAT_LETTER: begin
        if (scanning != 0 || ltr >= ALPHABET) return;
        ch = kids[cursor*ALPHABET + ltr];
        if (ch == 0) begin
          if (node_cnt >= MAX_NODES) begin
            ovf_seen = 1'b1;
            return;
          end
          ch = node_cnt;
          node_cnt++;
          kids[cursor*ALPHABET + ltr] = node_t'(ch);
        end
        cursor = ch;
      end
      KIND_PAT_END: begin
        if (scanning != 0) return;
        if (pat_cnt >= MAX_PATTERNS) ovf_seen = 1'b1;
        else begin
          ends[pat_cnt] = node_t'(cursor);
          pat_cnt++;
        end
        cursor = 0;
      end
      KIND_TEXT: begin
        if (ltr >= ALPHABET) return;
        if (scanning == 0) link_trie();
        k = walker;
        while (k != 0 && kids[k*ALPHABET + ltr] == 0) k = fails[k];
        if (kids[k*ALPHABET + ltr] != 0) k = kids[k*ALPHABET + ltr];
        hits[k] = bump(hits[k], 1);
        walker = k;
      end
      default: begin
        if (scanning == 0) link_trie();
        for (int i = node_cnt; i > 1; i--) begin
          nd = order[i-1];
          if (nd != 0 && hits[nd] != 0)
            hits[fails[nd]] = bump(hits[fails[nd]], hits[nd]);
        end
        for (int i = 0; i < pat_cnt; i++) begin
          t.pidx = i[PAT_W-1:0];
          t.cnt = hits[ends[i]];
          t.ovf = ovf_seen;
          t.lst = (i + 1 == pat_cnt);
          expected_tallies.insert(expected_tallies.size(), t);
        end
        clear_dictionary();
      end
    endcase
  endfunction

  // busy is sampled at the falling edge, ahead of the edge that accepts
  task automatic send_item(kind_t kind, logic [LETTER_W-1:0] ltr);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= kind;
    in_letter <= ltr;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
    predict_tallies(kind, ltr);
    items_sent++;
  endtask

  task automatic send_word(string w);
    for (int i = 0; i < w.len(); i++) send_item(KIND_PAT_LETTER, LETTER_W'(w[i] - "a"));
    send_item(KIND_PAT_END, '0);
  endtask

  task automatic send_text(string w);
    for (int i = 0; i < w.len(); i++) send_item(KIND_TEXT, LETTER_W'(w[i] - "a"));
  endtask

  task automatic test_directed();
    send_word("ab");
    send_word("b");
    send_word("");           // empty pattern counts the text length
    send_word("z");
    send_item(KIND_PAT_LETTER, 5'd31);  // out of alphabet, ignored
    send_item(KIND_PAT_LETTER, 5'd7);   // left open at finish
    send_text("abzab");
    send_item(KIND_TEXT, 5'd26);
    send_item(KIND_PAT_LETTER, 5'd0);   // loading after text is ignored
    send_item(KIND_PAT_END, 5'd0);
    send_item(KIND_FINISH, 5'd0);
    send_item(KIND_FINISH, 5'd0);       // no patterns
    send_word("q");
    send_item(KIND_FINISH, 5'd0);       // finish without text
  endtask

  task automatic test_pattern_table_full();
    for (int i = 0; i <= MAX_PATTERNS; i++) send_item(KIND_PAT_END, '0);
    send_text("ab");
    send_item(KIND_FINISH, '0);
  endtask

  task automatic test_node_table_full();
    for (int i = 0; i < MAX_NODES + 4; i++)
      send_item(KIND_PAT_LETTER, LETTER_W'(i % 3));
    send_item(KIND_PAT_END, '0);
    send_word("ba");
    for (int i = 0; i < 30; i++) send_item(KIND_TEXT, LETTER_W'($urandom_range(0, 2)));
    send_item(KIND_FINISH, '0);
  endtask

  task automatic test_random(int pct, int budget);
    int stop_at, span;
    idle_pct = pct;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      span = ($urandom_range(9) == 0) ? 25 : 3;
      repeat ($urandom_range(0, 6)) begin
        repeat ($urandom_range(0, 4)) begin
          if ($urandom_range(9) == 0)
            send_item(kind_t'($urandom_range(3)), LETTER_W'($urandom_range(31)));
          else send_item(KIND_PAT_LETTER, LETTER_W'($urandom_range(0, span)));
        end
        send_item(KIND_PAT_END, '0);
      end
      repeat ($urandom_range(5, 40)) begin
        if ($urandom_range(19) == 0)
          send_item(kind_t'($urandom_range(2)), LETTER_W'($urandom_range(31)));
        else send_item(KIND_TEXT, LETTER_W'($urandom_range(0, span)));
      end
      send_item(KIND_FINISH, LETTER_W'($urandom_range(31)));
    end
  endtask

  always @(negedge clk) begin
    tally_t t;
    if (out_valid) begin
      if (expected_tallies.size() == 0) begin
        $error("unexpected count for pattern %0d", out_pattern_index);
        broken = 1'b1;
      end else begin
        t = expected_tallies.pop_front();
        if (out_pattern_index !== t.pidx) begin
          $error("pattern_index: expected %0d, got %0d", t.pidx, out_pattern_index);
          broken = 1'b1;
        end
        if (out_match_count !== t.cnt) begin
          $error("match_count: expected %0d, got %0d", t.cnt, out_match_count);
          broken = 1'b1;
        end
        if (out_overflow !== t.ovf) begin
          $error("overflow: expected %0b, got %0b", t.ovf, out_overflow);
          broken = 1'b1;
        end
        if (out_last !== t.lst) begin
          $error("last: expected %0b, got %0b", t.lst, out_last);
          broken = 1'b1;
        end
      end
    end
    if (out_valid || (start && !busy)) quiet = 0;
    else quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int waited;
    clear_dictionary();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_pattern_table_full();
    test_node_table_full();
    test_random(35, 150);
    test_random(73, 150);
    test_random(0, 150);
    start <= 1'b0;
    waited = 0;
    while ((expected_tallies.size() != 0 || busy) && waited < STALL_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (!broken && expected_tallies.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

FILE: filelist.f
sv/acmc_pkg.sv
sv/acmc_ram.sv
sv/aho_corasick_match_counter.sv
tb/sv/aho_corasick_match_counter_test.sv
